@@ hdl/bswb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswb_pkg
// Types, constants and codes shared by the bilinear sampler modules.
// ----------------------------------------------------------------------------
package bswb_pkg;

	localparam int IDX_BITS        = 8;
	localparam int FRAC_BITS       = 8;
	localparam int PIXEL_BITS      = 16;
	localparam int COORD_BITS      = 24;
	localparam int RESULT_BITS     = 24;
	localparam int DIM_BITS        = IDX_BITS + 1;
	localparam int MOD_BITS        = DIM_BITS + 1;
	localparam int INT_BITS        = COORD_BITS - FRAC_BITS + 1;
	localparam int MAG_BITS        = INT_BITS - 1;
	localparam int STEPS_PER_CYCLE = 6;
	localparam int MOD_CYCLES      = (MAG_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
	localparam int SHIFT_BITS      = MOD_CYCLES * STEPS_PER_CYCLE;
	localparam int STEP_BITS       = $clog2(MOD_CYCLES + 1);
	localparam int WGT_BITS        = FRAC_BITS + 1;
	localparam int PROD_BITS       = 2 * FRAC_BITS + 1;
	localparam int ACC_BITS        = PIXEL_BITS + 2 * FRAC_BITS;
	localparam int PIXELS          = 1 << (2 * IDX_BITS);
	localparam int APB_ADDR_BITS   = 4;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(1) << IDX_BITS;
	localparam logic [WGT_BITS-1:0] WGT_ONE = WGT_BITS'(1) << FRAC_BITS;

	// border modes
	localparam logic [1:0] BORDER_OUTSIDE   = 2'd0;
	localparam logic [1:0] BORDER_CIRCULAR  = 2'd1;
	localparam logic [1:0] BORDER_REPLICATE = 2'd2;
	localparam logic [1:0] BORDER_SYMMETRIC = 2'd3;

	// opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE_X = 2'd2;
	localparam logic [1:0] REG_MODE_Y = 2'd3;

	typedef struct packed {
		logic                         opcode;
		logic [IDX_BITS-1:0]          pixel_column;
		logic [IDX_BITS-1:0]          pixel_row;
		logic [PIXEL_BITS-1:0]        pixel_value;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic [RESULT_BITS-1:0] sample_value;
		logic                   outside;
	} out_item_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] n_x;
		logic [DIM_BITS-1:0] n_y;
		logic [1:0]          mode_x;
		logic [1:0]          mode_y;
	} cfg_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] lo;
		logic [IDX_BITS-1:0] hi;
		logic [WGT_BITS-1:0] w_lo;
		logic [WGT_BITS-1:0] w_hi;
		logic                ok;
	} axis_t;

	typedef struct packed {
		logic                  is_load;
		logic [IDX_BITS-1:0]   col;
		logic [IDX_BITS-1:0]   row;
		logic [PIXEL_BITS-1:0] value;
		axis_t                 x;
		axis_t                 y;
	} op_t;

endpackage

@@ hdl/bswb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswb_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bswb_in_if;
	import bswb_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bswb_out_if;
	import bswb_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/bswb_coord.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswb_coord
// Splits coordinates into neighbour indices and weights, runs one modulo
// lane per axis and maps indices through the border mode.
// ----------------------------------------------------------------------------
module bswb_coord (
	input  logic           clk,
	input  logic           arst_n,
	bswb_in_if.sink        items,
	input  bswb_pkg::cfg_t cfg,
	output logic           op_valid,
	input  logic           op_ready,
	output bswb_pkg::op_t  op
);
	import bswb_pkg::*;

	typedef struct packed {
		logic [IDX_BITS-1:0] lo;
		logic [IDX_BITS-1:0] hi;
		logic                ok;
	} idx_t;

	logic                       busy_q;
	logic                       load_q;
	logic [STEP_BITS-1:0]       step_q;
	in_item_t                   item_q;
	logic signed [INT_BITS-1:0] lo_x_q, lo_y_q;
	logic [MOD_BITS-1:0]        rem_x_q, rem_y_q;
	logic [SHIFT_BITS-1:0]      sh_x_q, sh_y_q;
	logic                       op_valid_q;
	op_t                        op_q;

	logic signed [INT_BITS-1:0] lo_x_in, lo_y_in;
	logic [MOD_BITS-1:0]        div_x, div_y;
	logic                       finished, move, accept;
	idx_t                       map_x, map_y;
	op_t                        op_next;

	function automatic logic [MOD_BITS-1:0] divisor(input logic [1:0] mode,
		input logic [DIM_BITS-1:0] n);
		return (mode == BORDER_SYMMETRIC) ? {n, 1'b0} : {1'b0, n};
	endfunction

	// floor of coordinate minus one
	function automatic logic signed [INT_BITS-1:0] lower(input logic signed [COORD_BITS-1:0] c);
		return $signed({c[COORD_BITS-1], c[COORD_BITS-1:FRAC_BITS]}) - INT_BITS'(1);
	endfunction

	// magnitude to reduce: negative values use the ones' complement
	function automatic logic [SHIFT_BITS-1:0] magnitude(input logic signed [INT_BITS-1:0] v);
		logic [MAG_BITS-1:0] m;
		m = v[INT_BITS-1] ? ~v[MAG_BITS-1:0] : v[MAG_BITS-1:0];
		return SHIFT_BITS'(m);
	endfunction

	// restoring remainder steps, one bit each
	function automatic logic [MOD_BITS-1:0] mod_steps(input logic [MOD_BITS-1:0] rem,
		input logic [SHIFT_BITS-1:0] sh, input logic [MOD_BITS-1:0] m);
		logic [MOD_BITS:0]   t;
		logic [MOD_BITS-1:0] r;
		r = rem;
		for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
			t = {r, sh[SHIFT_BITS-1-i]};
			if (t >= {1'b0, m}) t = t - {1'b0, m};
			r = t[MOD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic idx_t map_axis(input logic signed [INT_BITS-1:0] lo,
		input logic frac_nz, input logic [1:0] mode, input logic [DIM_BITS-1:0] n,
		input logic [MOD_BITS-1:0] rem);
		logic [MOD_BITS-1:0]        m_div, m_lo, m_hi, n_w, f_lo, f_hi;
		logic signed [INT_BITS:0]   lo_x, hi_x, n_x;
		logic [IDX_BITS-1:0]        c_lo, c_hi, n_top;
		idx_t                       r;
		m_div = divisor(mode, n);
		n_w   = {1'b0, n};
		m_lo  = lo[INT_BITS-1] ? (m_div - MOD_BITS'(1) - rem) : rem;
		if (!frac_nz)
			m_hi = m_lo;
		else if ((m_lo + MOD_BITS'(1)) == m_div)
			m_hi = '0;
		else
			m_hi = m_lo + MOD_BITS'(1);
		f_lo  = (m_lo >= n_w) ? (m_div - MOD_BITS'(1) - m_lo) : m_lo;
		f_hi  = (m_hi >= n_w) ? (m_div - MOD_BITS'(1) - m_hi) : m_hi;
		lo_x  = {lo[INT_BITS-1], lo};
		hi_x  = lo_x + $signed({{INT_BITS{1'b0}}, frac_nz});
		n_x   = $signed({{(INT_BITS + 1 - DIM_BITS){1'b0}}, n});
		n_top = IDX_BITS'(n - DIM_BITS'(1));
		c_lo  = lo_x[INT_BITS] ? '0 : ((lo_x >= n_x) ? n_top : lo_x[IDX_BITS-1:0]);
		c_hi  = hi_x[INT_BITS] ? '0 : ((hi_x >= n_x) ? n_top : hi_x[IDX_BITS-1:0]);
		r = '0;
		unique case (mode)
			BORDER_OUTSIDE: begin
				r.ok = !lo_x[INT_BITS] && (lo_x < n_x) && !hi_x[INT_BITS] && (hi_x < n_x);
				r.lo = lo_x[IDX_BITS-1:0];
				r.hi = hi_x[IDX_BITS-1:0];
			end
			BORDER_CIRCULAR: begin
				r.ok = 1'b1;
				r.lo = m_lo[IDX_BITS-1:0];
				r.hi = m_hi[IDX_BITS-1:0];
			end
			BORDER_REPLICATE: begin
				r.ok = 1'b1;
				r.lo = c_lo;
				r.hi = c_hi;
			end
			BORDER_SYMMETRIC: begin
				r.ok = 1'b1;
				r.lo = f_lo[IDX_BITS-1:0];
				r.hi = f_hi[IDX_BITS-1:0];
			end
		endcase
		return r;
	endfunction

	assign lo_x_in  = lower(items.payload.coord_x);
	assign lo_y_in  = lower(items.payload.coord_y);
	assign div_x    = divisor(cfg.mode_x, cfg.n_x);
	assign div_y    = divisor(cfg.mode_y, cfg.n_y);
	assign finished = load_q || (step_q == STEP_BITS'(MOD_CYCLES));
	assign move     = busy_q && finished && (!op_valid_q || op_ready);
	assign items.ready = !busy_q || move;
	assign accept   = items.valid && items.ready;

	// border mapping and weights of the finished item
	always_comb begin
		map_x = map_axis(lo_x_q, item_q.coord_x[FRAC_BITS-1:0] != '0, cfg.mode_x, cfg.n_x,
			rem_x_q);
		map_y = map_axis(lo_y_q, item_q.coord_y[FRAC_BITS-1:0] != '0, cfg.mode_y, cfg.n_y,
			rem_y_q);
		op_next.is_load = load_q;
		op_next.col     = item_q.pixel_column;
		op_next.row     = item_q.pixel_row;
		op_next.value   = item_q.pixel_value;
		op_next.x.lo    = map_x.lo;
		op_next.x.hi    = map_x.hi;
		op_next.x.ok    = map_x.ok;
		op_next.x.w_hi  = {1'b0, item_q.coord_x[FRAC_BITS-1:0]};
		op_next.x.w_lo  = WGT_ONE - op_next.x.w_hi;
		op_next.y.lo    = map_y.lo;
		op_next.y.hi    = map_y.hi;
		op_next.y.ok    = map_y.ok;
		op_next.y.w_hi  = {1'b0, item_q.coord_y[FRAC_BITS-1:0]};
		op_next.y.w_lo  = WGT_ONE - op_next.y.w_hi;
	end

	// control of the work register and the op register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			load_q     <= 1'b0;
			step_q     <= '0;
			op_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				load_q <= (items.payload.opcode == OP_LOAD);
				step_q <= '0;
			end else if (move) begin
				busy_q <= 1'b0;
			end else if (busy_q && !finished) begin
				step_q <= step_q + STEP_BITS'(1);
			end
			if (move)
				op_valid_q <= 1'b1;
			else if (op_ready)
				op_valid_q <= 1'b0;
		end
	end

	// payload and modulo lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= items.payload;
			lo_x_q  <= lo_x_in;
			lo_y_q  <= lo_y_in;
			rem_x_q <= '0;
			rem_y_q <= '0;
			sh_x_q  <= magnitude(lo_x_in);
			sh_y_q  <= magnitude(lo_y_in);
		end else if (busy_q && !finished) begin
			rem_x_q <= mod_steps(rem_x_q, sh_x_q, div_x);
			rem_y_q <= mod_steps(rem_y_q, sh_y_q, div_y);
			sh_x_q  <= sh_x_q << STEPS_PER_CYCLE;
			sh_y_q  <= sh_y_q << STEPS_PER_CYCLE;
		end
		if (move)
			op_q <= op_next;
	end

	assign op_valid = op_valid_q;
	assign op       = op_q;

endmodule

@@ hdl/bswb_fetch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bswb_fetch
// Image memory with its access sequencer: writes loaded pixels, reads the
// four neighbours of a sample one per cycle, weights and sums them, and
// buffers results in a two-slot queue.
// ----------------------------------------------------------------------------
module bswb_fetch (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_ready,
	input  bswb_pkg::op_t op,
	bswb_out_if.source    results
);
	import bswb_pkg::*;

	localparam int                SLOTS = 2;
	localparam logic [1:0]        LAST_BEAT = 2'd3;
	localparam logic [ACC_BITS-1:0] ROUND = ACC_BITS'(1) << (FRAC_BITS - 1);

	logic [PIXEL_BITS-1:0] mem [0:PIXELS-1];
	logic [PIXEL_BITS-1:0] rd_data_q;

	logic [1:0]            beat_q;
	logic [1:0]            pending_q;
	logic                  v_s1, first_s1, last_s1, out_s1;
	logic [PROD_BITS-1:0]  weight_s1;
	logic                  v_s2, first_s2, last_s2, out_s2;
	logic [ACC_BITS-1:0]   prod_s2;
	logic [ACC_BITS-1:0]   acc_q;
	out_item_t             slot_q [0:SLOTS-1];
	logic                  wptr_q, rptr_q;
	logic [1:0]            count_q;

	logic                  is_out, credit, issue, do_write, do_read, first, last;
	logic [2*IDX_BITS-1:0] addr;
	logic [WGT_BITS-1:0]   wx, wy;
	logic [ACC_BITS-1:0]   acc_next;
	logic                  push, pop, start;

	assign is_out = !(op.x.ok && op.y.ok);
	assign credit = pending_q < 2'(SLOTS);

	// beat issue towards the memory port
	always_comb begin
		issue    = 1'b0;
		do_write = 1'b0;
		do_read  = 1'b0;
		op_ready = 1'b0;
		first    = (beat_q == '0);
		last     = 1'b0;
		if (op_valid) begin
			if (op.is_load) begin
				do_write = 1'b1;
				op_ready = 1'b1;
			end else if (!first || credit) begin
				issue = 1'b1;
				if (is_out) begin
					last     = 1'b1;
					op_ready = 1'b1;
				end else begin
					do_read  = 1'b1;
					last     = (beat_q == LAST_BEAT);
					op_ready = last;
				end
			end
		end
		addr = do_write ? {op.row, op.col}
			: {beat_q[1] ? op.y.hi : op.y.lo, beat_q[0] ? op.x.hi : op.x.lo};
		wx = beat_q[0] ? op.x.w_hi : op.x.w_lo;
		wy = beat_q[1] ? op.y.w_hi : op.y.w_lo;
	end

	assign start    = issue && first;
	assign acc_next = (first_s2 ? ROUND : acc_q) + prod_s2;
	assign push     = v_s2 && last_s2;
	assign pop      = results.valid && results.ready;

	// image memory, single port
	always_ff @(posedge clk) begin
		if (do_write)
			mem[addr] <= op.value;
		else if (do_read)
			rd_data_q <= mem[addr];
	end

	// sequencer, pipeline valids and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q    <= '0;
			pending_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wptr_q    <= 1'b0;
			rptr_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			if (issue)
				beat_q <= (last || is_out) ? '0 : beat_q + 2'd1;
			pending_q <= pending_q + 2'(start) - 2'(pop);
			v_s1      <= issue;
			v_s2      <= v_s1;
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// weighting and accumulation
	always_ff @(posedge clk) begin
		first_s1  <= first;
		last_s1   <= last;
		out_s1    <= is_out;
		weight_s1 <= PROD_BITS'(wx) * PROD_BITS'(wy);
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		out_s2    <= out_s1;
		prod_s2   <= ACC_BITS'(rd_data_q) * ACC_BITS'(weight_s1);
		if (v_s2)
			acc_q <= acc_next;
		if (push) begin
			slot_q[wptr_q].outside      <= out_s2;
			slot_q[wptr_q].sample_value <= out_s2 ? '0
				: RESULT_BITS'(acc_next >> FRAC_BITS);
		end
	end

	assign results.valid   = (count_q != '0);
	assign results.payload = slot_q[rptr_q];

endmodule

@@ hdl/bilinear_sample_with_borders.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_sample_with_borders
// Bilinear sampler of a stored image with per-axis border handling.
// ----------------------------------------------------------------------------
// The coordinate unit takes a new sample item as it hands the last one on:
// the four neighbouring pixels of a sample are read one per cycle from the
// single-port image memory while the modulo unit maps the next coordinate.
// A sample whose neighbour falls outside reads no pixel but is still paced
// by the coordinate unit. Load items write one pixel and give no result.
// Two results can wait at the output without stalling the memory. There is
// no clearing pass: pixels must be written before use.
// ----------------------------------------------------------------------------
module bilinear_sample_with_borders (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bswb_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [bswb_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [bswb_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	bswb_in_if.sink                              items,
	bswb_out_if.source                           results
);
	import bswb_pkg::*;

	logic [DIM_BITS-1:0] width_q, height_q;
	logic [1:0]          mode_x_q, mode_y_q;
	logic [1:0]          reg_idx;
	logic                cfg_write;
	cfg_t                cfg;
	logic                op_valid, op_ready;
	op_t                 op;

	// dimension of zero acts as one, beyond the store as the store size
	function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] n);
		if (n == '0)
			return DIM_BITS'(1);
		else if (n > DIM_MAX)
			return DIM_MAX;
		else
			return n;
	endfunction

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAX;
			height_q <= DIM_MAX;
			mode_x_q <= BORDER_OUTSIDE;
			mode_y_q <= BORDER_OUTSIDE;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				REG_MODE_X: mode_x_q <= pwdata[1:0];
				REG_MODE_Y: mode_y_q <= pwdata[1:0];
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			REG_MODE_X: prdata = APB_DATA_BITS'(mode_x_q);
			REG_MODE_Y: prdata = APB_DATA_BITS'(mode_y_q);
		endcase
	end

	assign cfg.n_x    = eff_dim(width_q);
	assign cfg.n_y    = eff_dim(height_q);
	assign cfg.mode_x = mode_x_q;
	assign cfg.mode_y = mode_y_q;

	bswb_coord u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	bswb_fetch u_fetch (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.results  (results)
	);

	// weights of each axis always sum to one
	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op.is_load |->
			(10'(op.x.w_lo) + 10'(op.x.w_hi)) == 10'(WGT_ONE) &&
			(10'(op.y.w_lo) + 10'(op.y.w_hi)) == 10'(WGT_ONE))
		else $error("neighbour weights do not sum to one");

	// mapped neighbours of an inside sample lie within the image in use
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op.is_load && op.x.ok && op.y.ok |->
			{1'b0, op.x.lo} < cfg.n_x && {1'b0, op.x.hi} < cfg.n_x &&
			{1'b0, op.y.lo} < cfg.n_y && {1'b0, op.y.hi} < cfg.n_y)
		else $error("mapped index beyond image size");

	// an op leaves the coordinate unit only once taken
	a_op_hold: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_ready |=> op_valid && $stable(op))
		else $error("op changed before transfer");

endmodule

@@ bench/bilinear_sample_with_borders_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_sample_with_borders_test
// Self-checking bench for the bilinear sampler with per-axis borders.
// ----------------------------------------------------------------------------
// Each phase writes the size and border registers over the APB port, loads
// every pixel of the region in use that is still unknown, then sends sample
// transfers mixed with stray pixel loads. Expected samples are computed at
// the accepting edge from a local copy of the image and the registers, and
// compared in order with the result channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module bilinear_sample_with_borders_test;
	import bswb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 30;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	bswb_in_if  item_ch ();
	bswb_out_if result_ch ();

	bilinear_sample_with_borders u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (item_ch.sink),
		.results (result_ch.source)
	);

	// local copy of the image and registers
	logic [PIXEL_BITS-1:0] pixel_copy [PIXELS];
	bit                    pixel_known [PIXELS];
	logic [8:0]            width_reg, height_reg;
	logic [1:0]            mode_x_reg, mode_y_reg;

	in_item_t  pending_items [$];
	out_item_t expected_samples [$];

	int cycle_count, quiet_cycles, mismatch_count;
	int load_count, sample_count, result_count, outside_count, phase_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit gap_now();
		if (cycle_count >= 3000 && cycle_count < 6000)
			return 1'b0;
		return $urandom_range(0, 99) < 25;
	endfunction

	function automatic longint eff_dim(logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return longint'(v);
	endfunction

	function automatic longint floor_mod(longint a, longint m);
		longint r;
		r = a % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	// apply the border mode to one index, report whether it lands inside
	function automatic bit fold_index(inout longint idx, input logic [1:0] mode,
			input longint n);
		case (mode)
			BORDER_CIRCULAR: idx = floor_mod(idx, n);
			BORDER_REPLICATE: begin
				if (idx >= n)
					idx = n - 1;
				else if (idx < 0)
					idx = 0;
			end
			BORDER_SYMMETRIC: begin
				idx = floor_mod(idx, 2 * n);
				if (idx >= n)
					idx = 2 * n - idx - 1;
			end
			default: ;
		endcase
		return idx >= 0 && idx < n;
	endfunction

	function automatic out_item_t interpolate(in_item_t it);
		out_item_t r;
		longint    vx, vy, xl, xh, yl, yh, fx, fy, acc;
		bit        ok;
		vx = longint'($signed(it.coord_x)) - 256;
		vy = longint'($signed(it.coord_y)) - 256;
		xl = vx >>> FRAC_BITS;
		yl = vy >>> FRAC_BITS;
		fx = vx & 255;
		fy = vy & 255;
		xh = (fx == 0) ? xl : xl + 1;
		yh = (fy == 0) ? yl : yl + 1;
		ok = fold_index(xl, mode_x_reg, eff_dim(width_reg));
		ok = fold_index(xh, mode_x_reg, eff_dim(width_reg)) && ok;
		ok = fold_index(yl, mode_y_reg, eff_dim(height_reg)) && ok;
		ok = fold_index(yh, mode_y_reg, eff_dim(height_reg)) && ok;
		r = '0;
		if (!ok) begin
			r.outside = 1'b1;
			return r;
		end
		acc = longint'(pixel_copy[yl * 256 + xl]) * (256 - fx) * (256 - fy)
			+ longint'(pixel_copy[yl * 256 + xh]) * fx * (256 - fy)
			+ longint'(pixel_copy[yh * 256 + xl]) * (256 - fx) * fy
			+ longint'(pixel_copy[yh * 256 + xh]) * fx * fy;
		r.sample_value = RESULT_BITS'((acc + 128) >> FRAC_BITS);
		return r;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			item_ch.payload <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (pending_items.size() > 0 && !gap_now()) begin
				item_ch.payload <= pending_items.pop_front();
				item_ch.valid   <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= !gap_now();
	end

	// predict accepted transfers, check results, watchdog
	always @(posedge clk) begin
		out_item_t want;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (item_ch.valid && item_ch.ready) begin
				moved = 1'b1;
				if (item_ch.payload.opcode == OP_LOAD) begin
					pixel_copy[{item_ch.payload.pixel_row, item_ch.payload.pixel_column}] =
						item_ch.payload.pixel_value;
					load_count++;
				end else begin
					expected_samples.push_back(interpolate(item_ch.payload));
					sample_count++;
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				result_count++;
				if (result_ch.payload.outside)
					outside_count++;
				if (expected_samples.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result value=%0h outside=%0b",
							result_ch.payload.sample_value, result_ch.payload.outside);
				end else begin
					want = expected_samples.pop_front();
					if (want.sample_value !== result_ch.payload.sample_value ||
							want.outside !== result_ch.payload.outside) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected value=%0h outside=%0b, got value=%0h outside=%0b",
								want.sample_value, want.outside,
								result_ch.payload.sample_value, result_ch.payload.outside);
					end
				end
			end
			if (moved || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic reg_write(logic [1:0] index, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_BITS'({index, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (index)
			REG_WIDTH:  width_reg  = value[8:0];
			REG_HEIGHT: height_reg = value[8:0];
			REG_MODE_X: mode_x_reg = value[1:0];
			default:    mode_y_reg = value[1:0];
		endcase
	endtask

	function automatic in_item_t load_item(int col, int row, logic [15:0] value);
		in_item_t it;
		it = '0;
		it.opcode       = OP_LOAD;
		it.pixel_column = col[7:0];
		it.pixel_row    = row[7:0];
		it.pixel_value  = value;
		it.coord_x      = 24'($urandom());
		it.coord_y      = 24'($urandom());
		return it;
	endfunction

	function automatic in_item_t sample_item(logic [23:0] cx, logic [23:0] cy);
		in_item_t it;
		it = '0;
		it.opcode       = OP_SAMPLE;
		it.pixel_column = 8'($urandom());
		it.pixel_row    = 8'($urandom());
		it.pixel_value  = 16'($urandom());
		it.coord_x      = cx;
		it.coord_y      = cy;
		return it;
	endfunction

	// coordinate that mostly lands near the image, sometimes anywhere
	function automatic logic [23:0] pick_coord(longint n);
		case ($urandom_range(0, 7))
			0: return 24'($urandom());
			1: return 24'($urandom_range(1, n) << 8);
			2, 3, 4: return 24'($urandom_range(256, n * 256 + 255));
			5: return 24'($urandom_range(0, 6 * n * 256) - 3 * n * 256);
			6: return $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
			default: return 24'($urandom_range(0, 1 << 16) - (1 << 15));
		endcase
	endfunction

	task automatic settle();
		wait (pending_items.size() == 0 && !item_ch.valid && expected_samples.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// set registers, fill the region in use, queue the samples
	task automatic run_phase(logic [8:0] w, logic [8:0] h, logic [1:0] mx,
			logic [1:0] my, int samples);
		longint ew, eh;
		settle();
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
		reg_write(REG_MODE_X, 32'(mx));
		reg_write(REG_MODE_Y, 32'(my));
		phase_count++;
		ew = eff_dim(w);
		eh = eff_dim(h);
		for (int r = 0; r < eh; r++)
			for (int c = 0; c < ew; c++)
				if (!pixel_known[r * 256 + c]) begin
					pixel_known[r * 256 + c] = 1'b1;
					pending_items.push_back(load_item(c, r, 16'($urandom())));
				end
		for (int i = 0; i < samples; i++) begin
			if ($urandom_range(0, 9) == 0)
				pending_items.push_back(load_item(int'($urandom()), int'($urandom()),
					16'($urandom())));
			pending_items.push_back(sample_item(pick_coord(ew), pick_coord(eh)));
		end
	endtask

	initial begin
		logic [23:0] dir_x [8];
		logic [23:0] dir_y [8];
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		width_reg = 9'd256; height_reg = 9'd256;
		mode_x_reg = BORDER_OUTSIDE; mode_y_reg = BORDER_OUTSIDE;
		cycle_count = 0; quiet_cycles = 0; mismatch_count = 0;
		load_count = 0; sample_count = 0; result_count = 0;
		outside_count = 0; phase_count = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 2x2 image with extreme pixels, corner and far coordinates
		pixel_known[0] = 1'b1; pixel_known[1] = 1'b1;
		pixel_known[256] = 1'b1; pixel_known[257] = 1'b1;
		pending_items.push_back(load_item(0, 0, 16'h0000));
		pending_items.push_back(load_item(1, 0, 16'hffff));
		pending_items.push_back(load_item(0, 1, 16'hffff));
		pending_items.push_back(load_item(1, 1, 16'hffff));
		dir_x = '{24'h000100, 24'h000200, 24'h000180, 24'h000000,
			24'h800000, 24'h7fffff, 24'h0001ff, 24'hffff01};
		dir_y = '{24'h000100, 24'h000200, 24'h000180, 24'h0000ff,
			24'h7fffff, 24'h800000, 24'h000101, 24'h000280};
		for (int m = 0; m < 4; m++) begin
			settle();
			reg_write(REG_WIDTH, 32'd2);
			reg_write(REG_HEIGHT, 32'd2);
			reg_write(REG_MODE_X, 32'(m[1:0]));
			reg_write(REG_MODE_Y, 32'(2'(3 - m)));
			for (int i = 0; i < 8; i++)
				pending_items.push_back(sample_item(dir_x[i], dir_y[i]));
		end

		// size extremes: full row, dimension zero and oversized values
		run_phase(9'd256, 9'd1, BORDER_SYMMETRIC, BORDER_CIRCULAR, 20);
		run_phase(9'd511, 9'd0, BORDER_CIRCULAR, BORDER_REPLICATE, 15);
		run_phase(9'd1, 9'd256, BORDER_REPLICATE, BORDER_SYMMETRIC, 20);
		run_phase(9'd0, 9'd300, BORDER_OUTSIDE, BORDER_CIRCULAR, 15);

		// random small images
		while (load_count + sample_count + pending_items.size() < 650)
			run_phase(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 40);

		settle();
		$display("phases %0d, pixel loads %0d, samples %0d, results %0d (%0d outside)",
			phase_count, load_count, sample_count, result_count, outside_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bswb_pkg.sv
hdl/bswb_if.sv
hdl/bswb_coord.sv
hdl/bswb_fetch.sv
hdl/bilinear_sample_with_borders.sv
bench/bilinear_sample_with_borders_test.sv
